>>> src/skvt_pkg.sv
// Shared types and constants for the sorted key/value table.
package skvt_pkg;

    localparam int SKVT_CAPACITY = 32;
    localparam int SKVT_KEY_BITS = 16;
    localparam int SKVT_QTY_BITS = 16;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_ERASE  = 3'd1,
        FN_LOOKUP = 3'd2,
        FN_UPDATE = 3'd3,
        FN_LIST   = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_UPDATE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_LIST
    } fsm_t;

    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

>>> src/skvt_cell.sv
// One table cell: holds a record, compares it to the request key, shifts with its neighbors.
module skvt_cell #(
    parameter int KEY_BITS = 16,
    parameter int QTY_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skvt_pkg::cell_op_t     op,
    input  logic [KEY_BITS-1:0]    req_key,
    input  logic [QTY_BITS-1:0]    req_qty,
    input  logic signed [15:0]     req_chg,
    input  logic                   lt_left,
    input  logic                   left_valid,
    input  logic [KEY_BITS-1:0]    left_key,
    input  logic [QTY_BITS-1:0]    left_qty,
    input  logic                   right_valid,
    input  logic [KEY_BITS-1:0]    right_key,
    input  logic [QTY_BITS-1:0]    right_qty,
    input  logic [KEY_BITS-1:0]    wrap_key,
    input  logic [QTY_BITS-1:0]    wrap_qty,
    output skvt_pkg::cell_flags_t  flags,
    output logic [KEY_BITS-1:0]    key,
    output logic [QTY_BITS-1:0]    qty,
    output logic [QTY_BITS-1:0]    upd_qty
);
    import skvt_pkg::*;

    localparam int SW = ((QTY_BITS > 16) ? QTY_BITS : 16) + 2;

    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  key_next;
    logic [QTY_BITS-1:0]  qty_reg;
    logic [QTY_BITS-1:0]  qty_next;
    logic                 lt;
    logic                 eq;
    logic signed [SW-1:0] sum;

    assign lt = valid_reg && (key_reg < req_key);
    assign eq = valid_reg && (key_reg == req_key);

    // saturating add of the signed change
    assign sum = $signed({{(SW-QTY_BITS){1'b0}}, qty_reg})
               + $signed({{(SW-16){req_chg[15]}}, req_chg});

    always_comb
    begin
        if (sum[SW-1])
        begin
            upd_qty = '0;
        end
        else if (|sum[SW-2:QTY_BITS])
        begin
            upd_qty = '1;
        end
        else
        begin
            upd_qty = sum[QTY_BITS-1:0];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        qty_next   = qty_reg;
        case (op)
            CELL_INSERT:
            begin
                if (!lt)
                begin
                    if (lt_left)
                    begin
                        valid_next = 1'b1;
                        key_next   = req_key;
                        qty_next   = req_qty;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        key_next   = left_key;
                        qty_next   = left_qty;
                    end
                end
            end
            CELL_ERASE:
            begin
                if (!lt)
                begin
                    valid_next = right_valid;
                    key_next   = right_key;
                    qty_next   = right_qty;
                end
            end
            CELL_UPDATE:
            begin
                if (eq)
                begin
                    qty_next = upd_qty;
                end
            end
            CELL_ROTATE:
            begin
                // last valid cell takes the head record
                if (valid_reg)
                begin
                    if (right_valid)
                    begin
                        key_next = right_key;
                        qty_next = right_qty;
                    end
                    else
                    begin
                        key_next = wrap_key;
                        qty_next = wrap_qty;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        qty_reg <= qty_next;
    end

    assign flags.valid = valid_reg;
    assign flags.lt    = lt;
    assign flags.eq    = eq;
    assign key         = key_reg;
    assign qty         = qty_reg;

endmodule

>>> src/sorted_key_value_table.sv
// Top level of the sorted key/value table: request FSM, cell chain and output register.
//
// Requests arrive on the in channel (in_valid/in_ready, fields func, part_key,
// qty_value, qty_change); results leave on the out channel (out_valid/out_ready,
// fields status, out_key, out_qty, last). Records live in a row of CAPACITY
// cells kept in ascending key order; all cells compare against the request key
// at once and shift one place left or right to erase or insert.
// A request is registered while idle and executed once the output register is
// free; insert, erase, lookup and update each give one result with last set.
// List gives one result per stored record, one per cycle while the output is
// not stalled, by rotating the chain through the head cell; it leaves the order
// unchanged. An empty table lists as a single empty status.
// Unknown request kinds are dropped without a result.
// The output register holds a result until it is taken; a stalled receiver
// stalls execution, while the next request may already be accepted.
// Reset empties the table at once; no clearing pass is needed.
module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::SKVT_CAPACITY,
    parameter int KEY_BITS = skvt_pkg::SKVT_KEY_BITS,
    parameter int QTY_BITS = skvt_pkg::SKVT_QTY_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic [15:0]        part_key,
    input  logic [15:0]        qty_value,
    input  logic signed [15:0] qty_change,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [15:0]        out_key,
    output logic [15:0]        out_qty,
    output logic               last
);
    import skvt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    fsm_t                 state_reg;
    fsm_t                 state_next;
    logic [2:0]           func_reg;
    logic [KEY_BITS-1:0]  rkey_reg;
    logic [QTY_BITS-1:0]  rqty_reg;
    logic signed [15:0]   rchg_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        idx_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [15:0]          key_reg;
    logic [15:0]          key_next;
    logic [15:0]          qty_reg;
    logic [15:0]          qty_next;
    logic                 last_reg;
    logic                 last_next;

    cell_op_t             cell_op;
    cell_flags_t          flags   [CAPACITY];
    logic [KEY_BITS-1:0]  ckey    [CAPACITY];
    logic [QTY_BITS-1:0]  cqty    [CAPACITY];
    logic [QTY_BITS-1:0]  cupd    [CAPACITY];
    logic                 lt_l    [CAPACITY];
    logic                 val_l   [CAPACITY];
    logic [KEY_BITS-1:0]  key_l   [CAPACITY];
    logic [QTY_BITS-1:0]  qty_l   [CAPACITY];
    logic                 val_r   [CAPACITY];
    logic [KEY_BITS-1:0]  key_r   [CAPACITY];
    logic [QTY_BITS-1:0]  qty_r   [CAPACITY];

    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  eq_vec;
    logic                 found;
    logic                 full;
    logic                 slot_free;
    logic [QTY_BITS-1:0]  hit_qty;
    logic [QTY_BITS-1:0]  hit_upd;
    logic [KEY_BITS+15:0] in_key_w;
    logic [QTY_BITS+15:0] in_qty_w;
    logic [KEY_BITS+15:0] rkey_w;
    logic [KEY_BITS+15:0] head_key_w;
    logic [QTY_BITS+15:0] rqty_w;
    logic [QTY_BITS+15:0] head_qty_w;
    logic [QTY_BITS+15:0] hit_qty_w;
    logic [QTY_BITS+15:0] hit_upd_w;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign lt_l[gi]  = 1'b1;
                assign val_l[gi] = 1'b0;
                assign key_l[gi] = '0;
                assign qty_l[gi] = '0;
            end
            else
            begin : g_mid
                assign lt_l[gi]  = flags[gi-1].lt;
                assign val_l[gi] = flags[gi-1].valid;
                assign key_l[gi] = ckey[gi-1];
                assign qty_l[gi] = cqty[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign val_r[gi] = 1'b0;
                assign key_r[gi] = '0;
                assign qty_r[gi] = '0;
            end
            else
            begin : g_body
                assign val_r[gi] = flags[gi+1].valid;
                assign key_r[gi] = ckey[gi+1];
                assign qty_r[gi] = cqty[gi+1];
            end

            skvt_cell #(
                .KEY_BITS (KEY_BITS),
                .QTY_BITS (QTY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op),
                .req_key     (rkey_reg),
                .req_qty     (rqty_reg),
                .req_chg     (rchg_reg),
                .lt_left     (lt_l[gi]),
                .left_valid  (val_l[gi]),
                .left_key    (key_l[gi]),
                .left_qty    (qty_l[gi]),
                .right_valid (val_r[gi]),
                .right_key   (key_r[gi]),
                .right_qty   (qty_r[gi]),
                .wrap_key    (ckey[0]),
                .wrap_qty    (cqty[0]),
                .flags       (flags[gi]),
                .key         (ckey[gi]),
                .qty         (cqty[gi]),
                .upd_qty     (cupd[gi])
            );

            assign valid_vec[gi] = flags[gi].valid;
            assign eq_vec[gi]    = flags[gi].eq;
        end
    endgenerate

    always_comb
    begin
        hit_qty = '0;
        hit_upd = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_qty = hit_qty | (cqty[i] & {QTY_BITS{eq_vec[i]}});
            hit_upd = hit_upd | (cupd[i] & {QTY_BITS{eq_vec[i]}});
        end
    end

    assign found     = |eq_vec;
    assign full      = (count_reg == CW'(CAPACITY));
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == FSM_IDLE);

    assign in_key_w   = {{KEY_BITS{1'b0}}, part_key};
    assign in_qty_w   = {{QTY_BITS{1'b0}}, qty_value};
    assign rkey_w     = {16'b0, rkey_reg};
    assign head_key_w = {16'b0, ckey[0]};
    assign rqty_w     = {16'b0, rqty_reg};
    assign head_qty_w = {16'b0, cqty[0]};
    assign hit_qty_w  = {16'b0, hit_qty};
    assign hit_upd_w  = {16'b0, hit_upd};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cell_op        = CELL_HOLD;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        key_next       = key_reg;
        qty_next       = qty_reg;
        last_next      = last_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (slot_free)
                begin
                    state_next     = FSM_IDLE;
                    out_valid_next = 1'b1;
                    key_next       = rkey_w[15:0];
                    qty_next       = '0;
                    last_next      = 1'b1;
                    case (func_reg)
                        FN_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (found)
                            begin
                                status_next = ST_DUPLICATE;
                                qty_next    = hit_qty_w[15:0];
                            end
                            else
                            begin
                                status_next = ST_OK;
                                qty_next    = rqty_w[15:0];
                                cell_op     = CELL_INSERT;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        FN_ERASE:
                        begin
                            if (found)
                            begin
                                status_next = ST_OK;
                                qty_next    = hit_qty_w[15:0];
                                cell_op     = CELL_ERASE;
                                count_next  = count_reg - 1'b1;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        FN_LOOKUP:
                        begin
                            if (found)
                            begin
                                status_next = ST_OK;
                                qty_next    = hit_qty_w[15:0];
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        FN_UPDATE:
                        begin
                            if (found)
                            begin
                                status_next = ST_OK;
                                qty_next    = hit_upd_w[15:0];
                                cell_op     = CELL_UPDATE;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        FN_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                key_next    = '0;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                key_next    = head_key_w[15:0];
                                qty_next    = head_qty_w[15:0];
                                last_next   = (count_reg == CW'(1));
                                cell_op     = CELL_ROTATE;
                                idx_next    = CW'(1);
                                if (count_reg != CW'(1))
                                begin
                                    state_next = FSM_LIST;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                        end
                    endcase
                end
            end
            FSM_LIST:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    key_next       = head_key_w[15:0];
                    qty_next       = head_qty_w[15:0];
                    last_next      = (idx_reg == count_reg - 1'b1);
                    cell_op        = CELL_ROTATE;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == count_reg - 1'b1)
                    begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            rkey_reg <= in_key_w[KEY_BITS-1:0];
            rqty_reg <= in_qty_w[QTY_BITS-1:0];
            rchg_reg <= qty_change;
        end
        status_reg <= status_next;
        key_reg    <= key_next;
        qty_reg    <= qty_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_key   = key_reg;
    assign out_qty   = qty_reg;
    assign last      = last_reg;

    // occupied cells always match the entry count
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell occupancy differs from entry count");

    // occupied cells form a prefix of the chain
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied cells are not contiguous from the head");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec))
        else $error("key matched in more than one cell");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_LIST) |-> (count_reg > CW'(1)) && (idx_reg < count_reg))
        else $error("list walk outside the stored records");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

endmodule
